[rtl/core/asgd_pkg.sv]
package asgd_pkg;

  localparam int NUM_PARAMS = 4096;
  localparam int SLOT_W     = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register stages between the input and the output buffer
  localparam int PIPE_DEPTH = 106;
  // stages plus the two-entry output buffer
  localparam int MAX_INFLIGHT = PIPE_DEPTH + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_LR    = 3'd1,
    REG_WD    = 3'd2,
    REG_BETA1 = 3'd3,
    REG_BETA2 = 3'd4,
    REG_EPS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   param_index;
    logic signed [31:0] weight;
    logic signed [31:0] gradient;
    logic               sweep_start;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic signed [31:0] new_weight;
  } out_item_t;

endpackage

[rtl/core/asgd_if.sv]
interface asgd_in_if;
  logic               valid;
  logic               ready;
  asgd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asgd_out_if;
  logic                valid;
  logic                ready;
  asgd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/adam_sgd_weight_update.sv]
// Channel    Dir  Transaction
// item_in    in   param_index, weight, gradient, sweep_start
// item_out   out  out_index, new_weight
// cfg_*      in   write enable, register index, data (no handshake)
//
// One item per cycle unless held; inputs cross the pipe registers to the output buffer.
// The depth is set by the bit-per-stage divider for the Adam ratio (64 stages)
// after the bit-per-stage square root of the second moment (32 stages).
// After reset the moment RAM is zeroed, one entry a cycle, all NUM_PARAMS = 4096 entries;
// item_in.ready stays low until that pass ends.
// The pipeline moves as a whole and holds when the two-entry output buffer is full.
module adam_sgd_weight_update (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [asgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asgd_pkg::CFG_DATA_W-1:0] cfg_data,
  asgd_in_if.sink                        item_in,
  asgd_out_if.source                     item_out
);
  import asgd_pkg::*;

  localparam logic [24:0] ONE_Q24  = 25'h100_0000;
  localparam logic [40:0] STEP_SAT = 41'h100_0000_0000;
  localparam int          LAST     = PIPE_DEPTH - 1;

  typedef struct packed {
    logic        mode;
    logic [23:0] lr;
    logic [23:0] wd;
    logic [23:0] beta1;
    logic [23:0] beta2;
    logic [15:0] eps;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:  1'b1,
    lr:    24'd16777,
    wd:    24'd0,
    beta1: 24'd15099494,
    beta2: 24'd16760439,
    eps:   16'd43
  };

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w;
    logic signed [31:0] g;
    logic [63:0]        g2;
    logic [24:0]        d1;
    logic [49:0]        sl_rem;
    logic [49:0]        sl_root;
    logic [48:0]        dl_num;
    logic [41:0]        dl_rem;
    logic [48:0]        dl_q;
    logic [48:0]        lr_t;
    logic signed [31:0] m;
    logic [63:0]        sv_rem;
    logic [63:0]        sv_root;
    logic [40:0]        den;
    logic [63:0]        dr_num;
    logic [41:0]        dr_rem;
    logic [63:0]        dr_q;
    logic [23:0]        lw;
    logic signed [31:0] sgd;
    logic [63:0]        pp0;
    logic [48:0]        pp1;
    logic [63:0]        pp2;
    logic [48:0]        pp3;
    logic [64:0]        mid;
    logic [112:0]       total;
    logic [40:0]        step;
    logic signed [31:0] w1;
    logic [31:0]        dec;
    logic signed [31:0] res;
  } item_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  typedef struct packed {
    logic [41:0] rem;
    logic [63:0] q;
  } dv_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    return SLOT_W'(32'(idx) % NUM_PARAMS);
  endfunction

  // one digit of the shift-and-subtract square root
  function automatic sq_t sqrt_iter(input logic [63:0] rem, input logic [63:0] root,
                                    input int i);
    sq_t         o;
    logic [63:0] bitv;
    logic [64:0] t;
    bitv = 64'd1 << (2 * i);
    t    = {1'b0, root} + {1'b0, bitv};
    if ({1'b0, rem} >= t) begin
      o.rem  = rem - t[63:0];
      o.root = (root >> 1) + bitv;
    end else begin
      o.rem  = rem;
      o.root = root >> 1;
    end
    return o;
  endfunction

  // one quotient bit of restoring division
  function automatic dv_t div_iter(input logic [41:0] rem, input logic [63:0] q,
                                   input logic [63:0] num, input logic [40:0] den,
                                   input int i);
    dv_t         o;
    logic [41:0] r;
    r   = {rem[40:0], num[i]};
    o.q = q;
    if (r >= {1'b0, den}) begin
      r      = r - {1'b0, den};
      o.q[i] = 1'b1;
    end
    o.rem = r;
    return o;
  endfunction

  function automatic item_t advance(input int k, input item_t p, input cfg_t c,
                                    input logic signed [31:0] m_upd,
                                    input logic [63:0] v_upd);
    item_t              n;
    sq_t                sq;
    dv_t                dv;
    logic [47:0]        lwp;
    logic [55:0]        sp;
    logic signed [63:0] sd;
    logic [63:0]        r;
    logic signed [42:0] ws;
    logic signed [42:0] ss;
    logic signed [42:0] wsum;
    logic [55:0]        dp;
    logic signed [32:0] w1e;
    logic signed [32:0] dece;
    logic signed [32:0] rsum;
    n = p;
    // bias-correction square root
    if (k <= 24) begin
      sq = sqrt_iter({14'b0, p.sl_rem}, {14'b0, p.sl_root}, 24 - k);
      n.sl_rem  = sq.rem[49:0];
      n.sl_root = sq.root[49:0];
    end
    if (k == 1) begin
      n.m       = m_upd;
      n.sv_rem  = v_upd;
      n.sv_root = '0;
    end
    if (k == 2) begin
      lwp  = 48'(c.lr) * 48'(c.wd);
      n.lw = lwp[47:24];
    end
    if (k == 3) begin
      sp    = 56'(mag32(p.g)) * 56'(c.lr);
      sd    = p.g[31] ? -$signed({32'b0, sp[55:24]}) : $signed({32'b0, sp[55:24]});
      n.sgd = sat32({{32{p.w[31]}}, p.w} - sd);
    end
    // second-moment square root
    if (k >= 2 && k <= 33) begin
      sq = sqrt_iter(p.sv_rem, p.sv_root, 33 - k);
      n.sv_rem  = sq.rem;
      n.sv_root = sq.root;
    end
    if (k == 25) begin
      n.dl_num = 49'(c.lr) * 49'(p.sl_root[24:0]);
      n.dl_rem = '0;
      n.dl_q   = '0;
    end
    if (k >= 26 && k <= 74) begin
      dv = div_iter(p.dl_rem, {15'b0, p.dl_q}, {15'b0, p.dl_num}, {16'b0, p.d1}, 74 - k);
      n.dl_rem = dv.rem;
      n.dl_q   = dv.q[48:0];
    end
    if (k == 75) begin
      n.lr_t = (p.d1 == '0) ? '0 : p.dl_q;
    end
    if (k == 34) begin
      n.den    = {1'b0, p.sv_root[31:0], 8'b0} + 41'(c.eps);
      n.dr_num = {mag32(p.m), 32'b0};
      n.dr_rem = '0;
      n.dr_q   = '0;
    end
    if (k >= 35 && k <= 98) begin
      dv = div_iter(p.dr_rem, p.dr_q, p.dr_num, p.den, 98 - k);
      n.dr_rem = dv.rem;
      n.dr_q   = dv.q;
    end
    if (k == 99) begin
      r      = (p.den == '0) ? '0 : p.dr_q;
      n.dr_q = r;
      n.pp0  = 64'(r[31:0]) * 64'(p.lr_t[31:0]);
      n.pp1  = 49'(r[31:0]) * 49'(p.lr_t[48:32]);
      n.pp2  = 64'(r[63:32]) * 64'(p.lr_t[31:0]);
      n.pp3  = 49'(r[63:32]) * 49'(p.lr_t[48:32]);
    end
    if (k == 100) begin
      n.mid = 65'(p.pp1) + 65'(p.pp2);
    end
    if (k == 101) begin
      n.total = 113'(p.pp0) + (113'(p.mid) << 32) + (113'(p.pp3) << 64);
    end
    if (k == 102) begin
      // a product of 2^64 or more saturates to the step limit
      n.step = (|p.total[112:64]) ? STEP_SAT : {1'b0, p.total[63:24]};
      ws     = {{11{p.w[31]}}, p.w};
      ss     = $signed({2'b0, n.step});
      wsum   = p.m[31] ? (ws + ss) : (ws - ss);
      n.w1   = sat32(64'(wsum));
    end
    if (k == 103) begin
      dp    = 56'(mag32(p.w1)) * 56'(p.lw);
      n.dec = dp[55:24];
    end
    if (k == 104) begin
      w1e   = {p.w1[31], p.w1};
      dece  = $signed({1'b0, p.dec});
      rsum  = p.w1[31] ? (w1e + dece) : (w1e - dece);
      n.res = c.mode ? rsum[31:0] : p.sgd;
    end
    return n;
  endfunction

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:  cfg.mode  <= cfg_data[0];
        REG_LR:    cfg.lr    <= cfg_data;
        REG_WD:    cfg.wd    <= cfg_data;
        REG_BETA1: cfg.beta1 <= cfg_data;
        REG_BETA2: cfg.beta2 <= cfg_data;
        REG_EPS:   cfg.eps   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // output buffer and global advance
  out_item_t   obuf [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        en;
  logic        push;
  logic        pop;

  item_t                 pipe [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] pv;
  item_t                 nxt  [PIPE_DEPTH-1];

  assign en   = (count != 2'd2);
  assign push = en && pv[LAST];
  assign pop  = item_out.valid && item_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        obuf[wr_ptr] <= '{out_index: pipe[LAST].idx, new_weight: pipe[LAST].res};
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign item_out.valid = (count != 2'd0);
  assign item_out.data  = obuf[rd_ptr];

  // moment RAM clearing pass
  logic [SLOT_W-1:0] clr_addr;
  logic              clr_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_done <= 1'b0;
    end else if (!clr_done) begin
      if (clr_addr == SLOT_W'(NUM_PARAMS - 1)) begin
        clr_done <= 1'b1;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign item_in.ready = en && clr_done;

  logic accept;
  assign accept = item_in.valid && item_in.ready;

  // beta powers advance at a sweep start
  logic [24:0] p1;
  logic [24:0] p2;
  logic [48:0] p1_prod;
  logic [48:0] p2_prod;
  logic [24:0] p1_eff;
  logic [24:0] p2_eff;
  item_t       head;

  always_comb begin
    p1_prod = 49'(p1) * 49'(cfg.beta1);
    p2_prod = 49'(p2) * 49'(cfg.beta2);
    p1_eff  = item_in.data.sweep_start ? p1_prod[48:24] : p1;
    p2_eff  = item_in.data.sweep_start ? p2_prod[48:24] : p2;
    head         = '0;
    head.idx     = item_in.data.param_index;
    head.w       = item_in.data.weight;
    head.g       = item_in.data.gradient;
    head.g2      = 64'(mag32(item_in.data.gradient)) * 64'(mag32(item_in.data.gradient));
    head.d1      = ONE_Q24 - p1_eff;
    head.sl_rem  = {1'b0, ONE_Q24 - p2_eff, 24'b0};
    head.sl_root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= ONE_Q24;
      p2 <= ONE_Q24;
    end else if (accept) begin
      p1 <= p1_eff;
      p2 <= p2_eff;
    end
  end

  // moment read-modify-write at stage 1
  logic [95:0]        rdata;
  logic [95:0]        wdata;
  logic [SLOT_W-1:0]  raddr;
  logic [SLOT_W-1:0]  waddr;
  logic               ram_we;
  logic               upd_we;
  logic [SLOT_W-1:0]  s1_slot;

  logic               fw_valid;
  logic [SLOT_W-1:0]  fw_slot;
  logic signed [31:0] fw_m;
  logic [63:0]        fw_v;

  logic signed [31:0] m_old;
  logic [63:0]        v_old;
  logic signed [32:0] diff;
  logic [24:0]        c1;
  logic [24:0]        c2;
  logic signed [58:0] mprod;
  logic signed [58:0] madj;
  logic signed [34:0] msum;
  logic signed [31:0] m_upd;
  logic               g2_ge;
  logic [63:0]        vx;
  logic [64:0]        vhi;
  logic [48:0]        vlo;
  logic [63:0]        vdelta;
  logic [63:0]        v_upd;

  assign s1_slot = slot_of(pipe[1].idx);

  always_comb begin
    // the last write is newer than anything the RAM read may return
    if (fw_valid && (fw_slot == s1_slot)) begin
      m_old = fw_m;
      v_old = fw_v;
    end else begin
      m_old = rdata[95:64];
      v_old = rdata[63:0];
    end
    c1    = ONE_Q24 - {1'b0, cfg.beta1};
    c2    = ONE_Q24 - {1'b0, cfg.beta2};
    diff  = $signed({pipe[1].g[31], pipe[1].g}) - $signed({m_old[31], m_old});
    mprod = diff * $signed({1'b0, c1});
    madj  = mprod + (mprod[58] ? 59'sd16777215 : 59'sd0);
    msum  = $signed(madj[58:24]) + $signed({{3{m_old[31]}}, m_old});
    m_upd = sat32(64'(msum));

    g2_ge  = (pipe[1].g2 >= v_old);
    vx     = g2_ge ? (pipe[1].g2 - v_old) : (v_old - pipe[1].g2);
    vhi    = 65'(vx[63:24]) * 65'(c2);
    vlo    = 49'(vx[23:0]) * 49'(c2);
    vdelta = vhi[63:0] + 64'(vlo[48:24]);
    v_upd  = g2_ge ? (v_old + vdelta) : (v_old - vdelta);
  end

  assign upd_we = en && pv[1] && cfg.mode;
  assign ram_we = !clr_done || upd_we;
  assign waddr  = clr_done ? s1_slot : clr_addr;
  assign wdata  = clr_done ? {m_upd, v_upd} : '0;
  assign raddr  = en ? slot_of(pipe[0].idx) : s1_slot;

  asgd_ram #(
    .WIDTH (96),
    .DEPTH (NUM_PARAMS)
  ) u_moment_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (upd_we) begin
      fw_valid <= 1'b1;
      fw_slot  <= s1_slot;
      fw_m     <= m_upd;
      fw_v     <= v_upd;
    end
  end

  // pipeline
  for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_stage
    always_comb begin
      nxt[k] = advance(k, pipe[k], cfg, m_upd, v_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= head;
      for (int k = 0; k < PIPE_DEPTH - 1; k++) begin
        pipe[k+1] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[PIPE_DEPTH-2:0], accept};
    end
  end

endmodule

[rtl/core/asgd_ram.sv]
module asgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/asgd_checker.sv]
module asgd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [asgd_pkg::IDX_W-1:0] out_index,
  input logic [31:0]               new_weight
);
  import asgd_pkg::*;

  localparam int CNT_W = $clog2(MAX_INFLIGHT + 2);

  logic [CNT_W-1:0] outstanding;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // moment RAM is being cleared right after reset
  a_no_accept_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(new_weight))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> outstanding != '0)
    else $error("result without a matching input transaction");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> outstanding < CNT_W'(MAX_INFLIGHT))
    else $error("input taken with pipeline and buffer full");

endmodule

bind adam_sgd_weight_update asgd_checker u_asgd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item_in.valid),
  .in_ready   (item_in.ready),
  .out_valid  (item_out.valid),
  .out_ready  (item_out.ready),
  .out_index  (item_out.data.out_index),
  .new_weight (item_out.data.new_weight)
);
